>>> design/sfr_pkg.sv
// Shared types and constants for the serial frame receiver.
// No dependencies; imported by every module of the block.
package sfr_pkg;

    localparam logic [7:0] START_BYTE   = 8'h5B;
    localparam logic [2:0] PACKET_BOUND = 3'd5;
    localparam logic [6:0] LENGTH_CAP   = 7'd64;
    localparam logic [5:0] POS_MAX      = 6'd63;

    localparam logic [1:0] ROLE_A = 2'd1;
    localparam logic [1:0] ROLE_B = 2'd2;
    localparam logic [2:0] PKT_A  = 3'd2;
    localparam logic [2:0] PKT_B  = 3'd4;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_ROLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELOAD  = 3'd4;

    typedef enum logic [2:0] {
        ST_BUSY,
        ST_DELIVERED,
        ST_NOT_ADDR,
        ST_BAD_SUM,
        ST_BAD_LEN,
        ST_BAD_PKT,
        ST_BAD_DEV
    } t_status;

    typedef struct packed {
        logic [1:0]  role;
        logic [7:0]  device;
        logic [6:0]  limit;
        logic [15:0] timeout;
        logic [3:0]  reload;
    } t_cfg;

    typedef struct packed {
        logic        deliver;
        t_status     status;
        logic        online;
        logic        req;
        logic [15:0] count;
    } t_cmd;

    typedef struct packed {
        logic       we;
        logic [5:0] addr;
        logic [7:0] data;
    } t_wr;

    typedef struct packed {
        logic        is_payload;
        logic [4:0]  index;
        logic [7:0]  value;
        t_status     status;
        logic        online;
        logic        req;
        logic [15:0] count;
        logic        last;
    } t_out;

endpackage

>>> design/sfr_front.sv
// Front part: takes byte and tick requests, parses frames, runs the link watchdog.
// Depends on sfr_pkg; feeds sfr_queue and the payload store write port of sfr_back.
module sfr_front import sfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    input  logic       i_func,
    input  logic [7:0] i_byte,
    output logic       o_ready,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd,
    output t_wr        o_wr,
    input  logic       i_done
);

    typedef enum logic [2:0] {
        PH_START,
        PH_LEN,
        PH_PKT,
        PH_DEV,
        PH_DATA,
        PH_SUM
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [5:0]  r_flen, n_flen;
    logic [2:0]  r_pkt, n_pkt;
    logic [7:0]  r_sum, n_sum;
    logic [5:0]  r_fpos, n_fpos;
    logic [5:0]  r_spos, n_spos;
    logic [15:0] r_idle, n_idle;
    logic [3:0]  r_alive, n_alive;
    logic        r_online, n_online;
    logic [15:0] r_fcnt, n_fcnt;
    logic        r_pend, n_pend;

    logic        accept, fin, deliver, req, addressed;
    t_status     status;
    logic [15:0] idle_inc;
    logic [6:0]  limit;
    logic [7:0]  sum_add;
    logic [5:0]  fpos_inc;
    t_wr         wr;

    assign o_ready = !i_full && !(r_phase == PH_DATA && r_pend);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_phase   = r_phase;
        n_flen    = r_flen;
        n_pkt     = r_pkt;
        n_sum     = r_sum;
        n_fpos    = r_fpos;
        n_spos    = r_spos;
        n_idle    = r_idle;
        n_alive   = r_alive;
        n_online  = r_online;
        n_fcnt    = r_fcnt;
        fin       = 1'b0;
        deliver   = 1'b0;
        req       = 1'b0;
        addressed = 1'b0;
        status    = ST_BUSY;
        wr        = '0;
        idle_inc  = (r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1;
        limit     = (i_cfg.limit > LENGTH_CAP) ? LENGTH_CAP : i_cfg.limit;
        sum_add   = r_sum + i_byte;
        fpos_inc  = (r_fpos < POS_MAX) ? r_fpos + 6'd1 : r_fpos;
        if (i_func) begin
            n_idle = idle_inc;
            if (idle_inc > i_cfg.timeout) begin
                if (r_alive != 4'd0) begin
                    n_online = 1'b1;
                    n_alive  = r_alive - 4'd1;
                end else begin
                    n_online = 1'b0;
                end
                n_idle = '0;
            end
        end else begin
            unique case (r_phase)
                PH_START: begin
                    if (i_byte == START_BYTE) begin
                        n_sum   = START_BYTE;
                        n_phase = PH_LEN;
                        n_fpos  = 6'd1;
                    end else begin
                        n_fpos = '0;
                    end
                end
                PH_LEN: begin
                    if (i_byte < {1'b0, limit}) begin
                        n_flen  = i_byte[5:0];
                        n_sum   = sum_add;
                        n_phase = PH_PKT;
                        n_fpos  = r_fpos + 6'd1;
                    end else begin
                        status = ST_BAD_LEN;
                        fin    = 1'b1;
                    end
                end
                PH_PKT: begin
                    n_sum = sum_add;
                    n_pkt = i_byte[2:0];
                    if (i_byte < {5'b0, PACKET_BOUND}) begin
                        n_phase = PH_DEV;
                        n_fpos  = r_fpos + 6'd1;
                    end else begin
                        status = ST_BAD_PKT;
                        fin    = 1'b1;
                    end
                end
                PH_DEV: begin
                    n_sum = sum_add;
                    if (i_byte == i_cfg.device) begin
                        n_phase = PH_DATA;
                        n_spos  = '0;
                        n_fpos  = r_fpos + 6'd1;
                    end else begin
                        status = ST_BAD_DEV;
                        fin    = 1'b1;
                    end
                end
                PH_DATA: begin
                    wr.we   = 1'b1;
                    wr.addr = r_spos;
                    wr.data = i_byte;
                    if (r_spos < POS_MAX) begin
                        n_spos = r_spos + 6'd1;
                    end
                    n_fpos = fpos_inc;
                    n_sum  = sum_add;
                    if (fpos_inc >= r_flen) begin
                        n_sum   = 8'd0 - sum_add;
                        n_phase = PH_SUM;
                    end
                end
                PH_SUM: begin
                    if (i_byte == r_sum) begin
                        addressed = (i_cfg.role == ROLE_A && r_pkt == PKT_A) ||
                                    (i_cfg.role == ROLE_B && r_pkt == PKT_B);
                        if (addressed) begin
                            deliver = 1'b1;
                            req     = 1'b1;
                            status  = ST_DELIVERED;
                            n_fcnt  = r_fcnt + 16'd1;
                            n_alive = i_cfg.reload;
                        end else begin
                            status = ST_NOT_ADDR;
                        end
                        n_idle = '0;
                    end else begin
                        status = ST_BAD_SUM;
                    end
                    fin = 1'b1;
                end
                default: begin
                    fin = 1'b1;
                end
            endcase
            if (fin) begin
                n_phase = PH_START;
                n_fpos  = '0;
                n_spos  = '0;
                n_sum   = '0;
            end
        end
        n_pend = i_done ? 1'b0 : r_pend;
        if (accept && deliver) begin
            n_pend = 1'b1;
        end
    end

    assign o_push        = accept;
    assign o_cmd.deliver = deliver;
    assign o_cmd.status  = status;
    assign o_cmd.online  = n_online;
    assign o_cmd.req     = req;
    assign o_cmd.count   = n_fcnt;
    assign o_wr.we       = wr.we && accept;
    assign o_wr.addr     = wr.addr;
    assign o_wr.data     = wr.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_flen   <= '0;
            r_pkt    <= '0;
            r_sum    <= '0;
            r_fpos   <= '0;
            r_spos   <= '0;
            r_idle   <= '0;
            r_alive  <= '0;
            r_online <= 1'b1;
            r_fcnt   <= '0;
            r_pend   <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (accept) begin
                r_phase  <= n_phase;
                r_flen   <= n_flen;
                r_pkt    <= n_pkt;
                r_sum    <= n_sum;
                r_fpos   <= n_fpos;
                r_spos   <= n_spos;
                r_idle   <= n_idle;
                r_alive  <= n_alive;
                r_online <= n_online;
                r_fcnt   <= n_fcnt;
            end
        end
    end

`ifndef SYNTH
    a_no_write_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !o_wr.we)
        else $error("store write while a delivery is outstanding");

    a_single_delivery: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_cmd.deliver |-> !r_pend)
        else $error("second delivery queued before the first finished");

    a_sum_phase_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SUM |-> $past(r_phase) == PH_SUM || $past(r_phase) == PH_DATA)
        else $error("checksum phase entered from outside the payload phase");
`endif

endmodule

>>> design/sfr_queue.sv
// Short command queue between the frame parser and the result sequencer.
// Depends on sfr_pkg for the command type and depth.
module sfr_queue import sfr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_full,
    output logic o_empty
);

    localparam int QW = $clog2(QUEUE_DEPTH);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [QW-1:0] r_wp, r_rp;
    logic [QW:0]   r_count;

    assign o_full  = (r_count == (QW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QW+1)'(1);
            end
        end
    end

endmodule

>>> design/sfr_back.sv
// Back part: payload store and result sequencer with the output register.
// Depends on sfr_pkg; drains sfr_queue and takes store writes from sfr_front.
module sfr_back import sfr_pkg::*; #(
    parameter int PAYLOAD_DEPTH   = 64,
    parameter int DELIVERED_BYTES = 27
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_wr  i_wr,
    input  t_cmd i_head,
    input  logic i_empty,
    output logic o_pop,
    output logic o_done,
    output logic o_valid,
    output t_out o_out,
    input  logic i_ready
);

    localparam int AW = $clog2(PAYLOAD_DEPTH);
    localparam int IW = (DELIVERED_BYTES > 1) ? $clog2(DELIVERED_BYTES) : 1;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RD,
        BK_LD,
        BK_ST
    } t_state;

    t_state               r_state;
    logic [IW-1:0]        r_idx;
    logic                 r_ovalid;
    t_out                 r_out;
    logic [7:0]           r_store [PAYLOAD_DEPTH];
    logic [PAYLOAD_DEPTH-1:0] r_vld;
    logic [7:0]           r_rdata;
    logic                 r_rok;

    logic          out_free, wr_ok, rd_in, ld_out;
    logic [AW-1:0] wr_addr, rd_addr;
    t_out          st_res, pl_res;

    assign out_free = !r_ovalid || i_ready;
    assign wr_ok    = i_wr.we && (32'(i_wr.addr) < PAYLOAD_DEPTH);
    assign wr_addr  = AW'(i_wr.addr);
    assign rd_in    = 32'(r_idx) < PAYLOAD_DEPTH;
    assign rd_addr  = rd_in ? AW'(r_idx) : '0;

    assign o_done = (r_state == BK_ST) && out_free;
    assign o_pop  = o_done ||
                    (r_state == BK_IDLE && !i_empty && !i_head.deliver && out_free);
    assign ld_out = out_free &&
                    ((r_state == BK_IDLE && !i_empty && !i_head.deliver) ||
                     r_state == BK_LD || r_state == BK_ST);

    always_comb begin
        st_res            = '0;
        st_res.is_payload = 1'b0;
        st_res.status     = i_head.status;
        st_res.online     = i_head.online;
        st_res.req        = i_head.req;
        st_res.count      = i_head.count;
        st_res.last       = 1'b1;
    end

    always_comb begin
        pl_res            = '0;
        pl_res.is_payload = 1'b1;
        pl_res.index      = 5'(r_idx);
        pl_res.value      = r_rok ? r_rdata : 8'd0;
        pl_res.status     = ST_BUSY;
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_store[wr_addr] <= i_wr.data;
        end
        r_rdata <= r_store[rd_addr];
        r_rok   <= rd_in && r_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_ok) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
            r_out    <= '0;
        end else begin
            if (ld_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                BK_IDLE: begin
                    if (!i_empty) begin
                        if (i_head.deliver) begin
                            r_idx   <= '0;
                            r_state <= BK_RD;
                        end else if (out_free) begin
                            r_out <= st_res;
                        end
                    end
                end
                BK_RD: begin
                    r_state <= BK_LD;
                end
                BK_LD: begin
                    if (out_free) begin
                        r_out <= pl_res;
                        if (r_idx == IW'(DELIVERED_BYTES - 1)) begin
                            r_state <= BK_ST;
                        end else begin
                            r_idx   <= r_idx + IW'(1);
                            r_state <= BK_RD;
                        end
                    end
                end
                BK_ST: begin
                    if (out_free) begin
                        r_out   <= st_res;
                        r_state <= BK_IDLE;
                    end
                end
                default: begin
                    r_state <= BK_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_out   = r_out;

`ifndef SYNTH
    a_no_write_during_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.we |-> r_state != BK_RD && r_state != BK_LD)
        else $error("payload store written during delivery");

    a_payload_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_out.is_payload |-> !r_out.last)
        else $error("payload result marked last");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> r_state == BK_IDLE)
        else $error("sequencer did not return to idle after a delivery");
`endif

endmodule

>>> design/serial_frame_receiver_checksum.sv
// Top level of the serial frame receiver: config registers, parser, queue, sequencer.
// Depends on sfr_pkg, sfr_front, sfr_queue and sfr_back.
//
//  channel | direction | handshake               | payload
//  s       | in        | i_s_tvalid / o_s_tready | tdata rx_byte, tuser func
//  m       | out       | o_m_tvalid / i_m_tready | tdata fields, tuser is_payload, tlast
//  cfg     | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// The parser takes one request per cycle while the command queue has room and the wait below does not hold it.
// A status-only request enters the output register when it heads the queue and the register is free.
// A delivered frame runs through the sequencer as a start step, then
// one store read and one output load per payload byte, then the status result.
// A request in the payload phase waits until a pending delivery has read the store.
// Synchronous active-low reset; the store valid bits clear at once, no sweep.
module serial_frame_receiver_checksum import sfr_pkg::*; #(
    parameter int PAYLOAD_DEPTH   = 64,
    parameter int DELIVERED_BYTES = 27
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] rx_byte
    input  logic                  i_s_tuser,   // [0] func
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [39:0]           o_m_tdata,   // [4:0] payload_index, [12:5] payload_value,
                                               // [15:13] frame_status, [16] link_online,
                                               // [17] reply_request, [33:18] frames_received
    output logic                  o_m_tuser,   // [0] is_payload
    output logic                  o_m_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd push_cmd, head;
    t_wr  wr;
    t_out res;
    logic push, pop, full, empty, done;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.role    <= 2'd1;
            r_cfg.device  <= 8'd9;
            r_cfg.limit   <= 7'd60;
            r_cfg.timeout <= 16'd360;
            r_cfg.reload  <= 4'd10;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROLE:    r_cfg.role    <= i_cfg_data[1:0];
                CFG_DEVICE:  r_cfg.device  <= i_cfg_data[7:0];
                CFG_LIMIT:   r_cfg.limit   <= i_cfg_data[6:0];
                CFG_TIMEOUT: r_cfg.timeout <= i_cfg_data[15:0];
                CFG_RELOAD:  r_cfg.reload  <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    sfr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .i_func  (i_s_tuser),
        .i_byte  (i_s_tdata),
        .o_ready (o_s_tready),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd),
        .o_wr    (wr),
        .i_done  (done)
    );

    sfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    sfr_back #(
        .PAYLOAD_DEPTH   (PAYLOAD_DEPTH),
        .DELIVERED_BYTES (DELIVERED_BYTES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_done  (done),
        .o_valid (o_m_tvalid),
        .o_out   (res),
        .i_ready (i_m_tready)
    );

    assign o_m_tdata = {6'b0, res.count, res.req, res.online, res.status,
                        res.value, res.index};
    assign o_m_tuser = res.is_payload;
    assign o_m_tlast = res.last;

endmodule

>>> tb/serial_frame_receiver_checksum_tb.sv
// Self-checking testbench for serial_frame_receiver_checksum: random framed byte
// streams and timer ticks, predicted results compared on the output stream.
// Depends on sfr_pkg and the serial_frame_receiver_checksum RTL.
`timescale 1ns / 100ps

module serial_frame_receiver_checksum_tb;
    import sfr_pkg::*;

    localparam int PAYLOAD_DEPTH   = 64;
    localparam int DELIVERED_BYTES = 27;
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;
    localparam logic [1:0] ROLE_NONE  = 2'd0;
    localparam logic [1:0] ROLE_SPARE = 2'd3;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AT_A      = 120;
    localparam int HOLD_AT_B      = 400;
    localparam int STALL_LIMIT    = 4000;
    localparam int PHASE_ITEMS    = 36;

    typedef enum logic [2:0] {PH_WAIT, PH_LEN, PH_PKT, PH_DEV, PH_BODY, PH_SUM} t_phase;
    typedef enum logic [1:0] {STEP_IN, STEP_REG, STEP_SYNC} t_step_kind;

    typedef struct {
        t_step_kind                kind;
        logic                      func;
        logic [7:0]                data;
        logic [CFG_IDX_W-1:0]      idx;
        logic [CFG_DATA_W-1:0]     val;
    } t_step;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata = '0;
    logic                  i_s_tuser = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [39:0]           o_m_tdata;
    logic                  o_m_tuser;
    logic                  o_m_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    serial_frame_receiver_checksum #(
        .PAYLOAD_DEPTH  (PAYLOAD_DEPTH),
        .DELIVERED_BYTES(DELIVERED_BYTES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ---------------- receiver model ----------------
    t_cfg        regs = '{role: ROLE_A, device: 8'd9, limit: 7'd60, timeout: 16'd360,
                          reload: 4'd10};
    t_phase      parse_phase = PH_WAIT;
    logic [5:0]  frame_len = '0;
    logic [2:0]  pkt_num = '0;
    logic [7:0]  running_sum = '0;
    logic [5:0]  frame_pos = '0;
    logic [5:0]  store_pos = '0;
    logic [7:0]  payload_mem [PAYLOAD_DEPTH] = '{default: 8'h00};
    logic [15:0] idle_ticks = '0;
    logic [3:0]  alive_count = '0;
    logic        online_flag = 1'b1;
    logic [15:0] frame_count = '0;

    t_out rx_results [$];

    function automatic void close_frame();
        parse_phase = PH_WAIT;
        frame_pos   = '0;
        store_pos   = '0;
        running_sum = '0;
    endfunction

    function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        case (idx)
            CFG_ROLE:    regs.role    = v[1:0];
            CFG_DEVICE:  regs.device  = v[7:0];
            CFG_LIMIT:   regs.limit   = v[6:0];
            CFG_TIMEOUT: regs.timeout = v;
            CFG_RELOAD:  regs.reload  = v[3:0];
            default: ;
        endcase
    endfunction

    // Advances the model by one request and queues what it yields; returns the count.
    function automatic int deframe_step(logic func, logic [7:0] b);
        t_status    st;
        logic       rq;
        logic [6:0] lim;
        logic       hit;
        t_out       r;
        int         n;
        st = ST_BUSY;
        rq = 1'b0;
        n  = 0;
        if (func == FUNC_TICK) begin
            if (idle_ticks != 16'hFFFF)
                idle_ticks = idle_ticks + 16'd1;
            if (idle_ticks > regs.timeout) begin
                if (alive_count != 0) begin
                    online_flag = 1'b1;
                    alive_count = alive_count - 4'd1;
                end else begin
                    online_flag = 1'b0;
                end
                idle_ticks = '0;
            end
        end else begin
            lim = (regs.limit > LENGTH_CAP) ? LENGTH_CAP : regs.limit;
            case (parse_phase)
                PH_WAIT: begin
                    if (b == START_BYTE) begin
                        running_sum = START_BYTE;
                        parse_phase = PH_LEN;
                        frame_pos   = 6'd1;
                    end else begin
                        frame_pos = '0;
                    end
                end
                PH_LEN: begin
                    if (b < lim) begin
                        frame_len   = b[5:0];
                        running_sum = running_sum + b;
                        parse_phase = PH_PKT;
                        frame_pos   = frame_pos + 6'd1;
                    end else begin
                        st = ST_BAD_LEN;
                        close_frame();
                    end
                end
                PH_PKT: begin
                    running_sum = running_sum + b;
                    pkt_num     = b[2:0];
                    if (b < PACKET_BOUND) begin
                        parse_phase = PH_DEV;
                        frame_pos   = frame_pos + 6'd1;
                    end else begin
                        st = ST_BAD_PKT;
                        close_frame();
                    end
                end
                PH_DEV: begin
                    running_sum = running_sum + b;
                    if (b == regs.device) begin
                        parse_phase = PH_BODY;
                        store_pos   = '0;
                        frame_pos   = frame_pos + 6'd1;
                    end else begin
                        st = ST_BAD_DEV;
                        close_frame();
                    end
                end
                PH_BODY: begin
                    payload_mem[store_pos] = b;
                    if (store_pos < POS_MAX)
                        store_pos = store_pos + 6'd1;
                    if (frame_pos < POS_MAX)
                        frame_pos = frame_pos + 6'd1;
                    running_sum = running_sum + b;
                    if (frame_pos >= frame_len) begin
                        running_sum = 8'd0 - running_sum;
                        parse_phase = PH_SUM;
                    end
                end
                PH_SUM: begin
                    if (b == running_sum) begin
                        hit = (regs.role == ROLE_A && pkt_num == PKT_A) ||
                              (regs.role == ROLE_B && pkt_num == PKT_B);
                        if (hit) begin
                            for (int i = 0; i < DELIVERED_BYTES; i++) begin
                                r            = '0;
                                r.is_payload = 1'b1;
                                r.index      = i[4:0];
                                r.value      = payload_mem[i];
                                r.status     = ST_BUSY;
                                rx_results.push_back(r);
                                n++;
                            end
                            frame_count = frame_count + 16'd1;
                            alive_count = regs.reload;
                            rq = 1'b1;
                            st = ST_DELIVERED;
                        end else begin
                            st = ST_NOT_ADDR;
                        end
                        idle_ticks = '0;
                    end else begin
                        st = ST_BAD_SUM;
                    end
                    close_frame();
                end
                default: close_frame();
            endcase
        end
        r        = '0;
        r.status = st;
        r.online = online_flag;
        r.req    = rq;
        r.count  = frame_count;
        r.last   = 1'b1;
        rx_results.push_back(r);
        return n + 1;
    endfunction

    // ---------------- stimulus plan ----------------
    t_step      rx_stream [$];
    int         stim_items = 0;
    logic [1:0] gen_role = ROLE_A;
    logic [7:0] gen_dev = 8'd9;
    int         gen_lim = 60;

    task automatic push_in(logic func, logic [7:0] b);
        t_step s;
        s      = '{kind: STEP_IN, func: func, data: b, idx: '0, val: '0};
        rx_stream.push_back(s);
        stim_items++;
    endtask

    task automatic push_sync();
        t_step s;
        s = '{kind: STEP_SYNC, func: 1'b0, data: '0, idx: '0, val: '0};
        rx_stream.push_back(s);
    endtask

    task automatic push_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        t_step s;
        s = '{kind: STEP_REG, func: 1'b0, data: '0, idx: idx, val: v};
        rx_stream.push_back(s);
    endtask

    task automatic configure(logic [1:0] role, logic [7:0] dev, logic [6:0] lim,
                             logic [15:0] tmo, logic [3:0] rel);
        push_sync();
        push_reg(CFG_ROLE, {14'd0, role});
        push_reg(CFG_DEVICE, {8'd0, dev});
        push_reg(CFG_LIMIT, {9'd0, lim});
        push_reg(CFG_TIMEOUT, tmo);
        push_reg(CFG_RELOAD, {12'd0, rel});
        gen_role = role;
        gen_dev  = dev;
        gen_lim  = lim;
    endtask

    task automatic maybe_tick();
        if ($urandom_range(0, 19) == 0)
            push_in(FUNC_TICK, 8'($urandom));
    endtask

    task automatic push_frame(logic [7:0] len, logic [7:0] pkt, logic [7:0] dev, bit spoil);
        logic [7:0] sum;
        logic [7:0] v;
        int         eff;
        int         npay;
        eff = (gen_lim > 64) ? 64 : gen_lim;
        push_in(FUNC_BYTE, START_BYTE);
        sum = START_BYTE;
        maybe_tick();
        push_in(FUNC_BYTE, len);
        if (len >= eff)
            return;
        sum = sum + len;
        push_in(FUNC_BYTE, pkt);
        if (pkt >= PACKET_BOUND)
            return;
        sum = sum + pkt;
        maybe_tick();
        push_in(FUNC_BYTE, dev);
        if (dev != gen_dev)
            return;
        sum  = sum + dev;
        npay = (len < 5) ? 1 : len - 4;
        for (int i = 0; i < npay; i++) begin
            v = 8'($urandom);
            push_in(FUNC_BYTE, v);
            sum = sum + v;
            maybe_tick();
        end
        sum = 8'd0 - sum;
        if (spoil)
            sum = sum ^ 8'($urandom_range(1, 255));
        push_in(FUNC_BYTE, sum);
    endtask

    task automatic random_frame();
        int         eff;
        int         k;
        int         top;
        logic [7:0] len;
        logic [7:0] pkt;
        logic [7:0] dev;
        eff = (gen_lim > 64) ? 64 : gen_lim;
        k   = $urandom_range(0, 99);
        if (k < 8)
            len = 8'($urandom_range(255, eff));
        else if (k < 18)
            len = 8'($urandom_range(eff - 1, 0));
        else begin
            top = (eff - 1 < 12) ? eff - 1 : 12;
            len = 8'($urandom_range(top, 0));
        end
        k = $urandom_range(0, 99);
        if (k < 10)
            pkt = 8'($urandom_range(255, 5));
        else if (k < 55)
            pkt = (gen_role == ROLE_B) ? 8'(PKT_B) : 8'(PKT_A);
        else
            pkt = 8'($urandom_range(4, 0));
        dev = gen_dev;
        if ($urandom_range(0, 99) < 8)
            dev = gen_dev ^ 8'($urandom_range(1, 255));
        push_frame(len, pkt, dev, $urandom_range(0, 99) < 12);
    endtask

    // ---------------- sender ----------------
    int results_predicted = 0;
    int results_checked = 0;
    int n_err = 0;
    int tx_wait = 0;
    int quiet = 0;
    bit tx_calm = 1'b0;
    bit s_busy;
    bit c_busy;

    function automatic int draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    always @(posedge i_clk) begin : sender
        if (i_rst_n) begin
            s_busy = i_s_tvalid;
            c_busy = i_cfg_valid;
            if (i_s_tvalid && o_s_tready) begin
                results_predicted += deframe_step(i_s_tuser, i_s_tdata);
                s_busy = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                write_reg(i_cfg_index, i_cfg_data);
                c_busy = 1'b0;
            end
            if (results_predicted == results_checked && !s_busy && !c_busy)
                quiet++;
            else
                quiet = 0;
            if (!s_busy && !c_busy && rx_stream.size() != 0) begin
                if (tx_wait != 0) begin
                    tx_wait--;
                end else begin
                    case (rx_stream[0].kind)
                        STEP_IN: begin
                            i_s_tuser <= rx_stream[0].func;
                            i_s_tdata <= rx_stream[0].data;
                            s_busy = 1'b1;
                            void'(rx_stream.pop_front());
                            if ($urandom_range(0, 31) == 0)
                                tx_calm = !tx_calm;
                            tx_wait = draw_gap(tx_calm);
                        end
                        STEP_REG: begin
                            if (quiet >= SETTLE_CYCLES) begin
                                i_cfg_index <= rx_stream[0].idx;
                                i_cfg_data  <= rx_stream[0].val;
                                c_busy = 1'b1;
                                void'(rx_stream.pop_front());
                            end
                        end
                        default: begin
                            if (quiet >= SETTLE_CYCLES)
                                void'(rx_stream.pop_front());
                        end
                    endcase
                end
            end
            i_s_tvalid  <= s_busy;
            i_cfg_valid <= c_busy;
        end
    end

    // ---------------- output checker ----------------
    int rx_wait = 0;
    int n_seen = 0;
    bit rx_calm = 1'b0;

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_err++;
        end
    endfunction

    always @(posedge i_clk) begin : out_check
        t_out want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (rx_results.size() == 0) begin
                $error("result with none pending: tdata 0x%0h", o_m_tdata);
                n_err++;
            end else begin
                want = rx_results.pop_front();
                check_field("is_payload", 16'(want.is_payload), 16'(o_m_tuser));
                check_field("payload_index", 16'(want.index), 16'(o_m_tdata[4:0]));
                check_field("payload_value", 16'(want.value), 16'(o_m_tdata[12:5]));
                check_field("frame_status", 16'(want.status), 16'(o_m_tdata[15:13]));
                check_field("link_online", 16'(want.online), 16'(o_m_tdata[16]));
                check_field("reply_request", 16'(want.req), 16'(o_m_tdata[17]));
                check_field("frames_received", want.count, o_m_tdata[33:18]);
                check_field("tdata_pad", 16'd0, 16'(o_m_tdata[39:34]));
                check_field("last", 16'(want.last), 16'(o_m_tlast));
                results_checked <= results_checked + 1;
            end
            n_seen++;
            if ($urandom_range(0, 31) == 0)
                rx_calm = !rx_calm;
            rx_wait = draw_gap(rx_calm);
            if (n_seen == HOLD_AT_A || n_seen == HOLD_AT_B)
                rx_wait = LONG_HOLD;
        end else if (rx_wait != 0) begin
            rx_wait--;
        end
        i_m_tready <= (rx_wait == 0);
    end

    // ---------------- watchdog ----------------
    int stuck = 0;

    always @(posedge i_clk) begin : watchdog
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck == STALL_LIMIT) begin
            $display("serial_frame_receiver_checksum_tb: done, errors");
            $finish;
        end
    end

    // ---------------- stimulus and end of run ----------------
    initial begin : stimulus
        int  ph_end;
        int  k;
        bit  mid_done;
        // directed: idle noise, tick, delivered frame, length, packet and device rejects, short frame
        push_in(FUNC_BYTE, 8'h00);
        push_in(FUNC_TICK, 8'hFF);
        push_frame(8'd6, 8'(PKT_A), 8'd9, 1'b0);
        push_frame(8'd60, 8'(PKT_A), 8'd9, 1'b0);
        push_frame(8'd5, 8'd5, 8'd9, 1'b0);
        push_frame(8'd5, 8'(PKT_A), 8'd8, 1'b0);
        push_frame(8'd0, 8'd3, 8'd9, 1'b0);

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: configure(ROLE_B, 8'h00, 7'd5, 16'd0, 4'd0);
                1: configure(ROLE_A, 8'hFF, 7'd64, 16'd3, 4'd15);
                2: configure(ROLE_NONE, 8'hA5, 7'd127, 16'hFFFF, 4'd1);
                3: configure(ROLE_SPARE, 8'h5A, 7'd20, 16'd1, 4'd5);
                default: configure(2'($urandom_range(2, 0)), 8'($urandom),
                                   7'($urandom_range(64, 5)), 16'($urandom_range(10, 0)),
                                   4'($urandom));
            endcase
            ph_end   = stim_items + PHASE_ITEMS;
            mid_done = 1'b0;
            while (stim_items < ph_end) begin
                if (!mid_done && stim_items >= ph_end - PHASE_ITEMS / 2) begin
                    push_sync();
                    mid_done = 1'b1;
                end
                k = $urandom_range(0, 99);
                if (k < 6)
                    push_in(FUNC_BYTE, 8'($urandom));
                else if (k < 16)
                    push_in(FUNC_TICK, 8'($urandom));
                else
                    random_frame();
            end
        end

        @(posedge i_clk);
        while (!i_rst_n || rx_stream.size() != 0 || i_s_tvalid || i_cfg_valid ||
               results_predicted != results_checked)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_err == 0)
            $display("serial_frame_receiver_checksum_tb: done, clean");
        else
            $display("serial_frame_receiver_checksum_tb: done, errors");
        $finish;
    end

endmodule
